FILE: rtl/spi_pkg.sv
// ----------------------------------------------------------------------------
// spi_pkg
// Shared types and constants of the segment point interpolator.
// ----------------------------------------------------------------------------
package spi_pkg;

    localparam int unsigned MaxPoints = 64;
    localparam int unsigned CntW      = $clog2(MaxPoints);
    localparam logic [31:0] SpacingRst = 32'h0001_0000;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [CntW-1:0]    count;
        logic               clipped;
    } t_job;

endpackage

FILE: rtl/spi_front.sv
// ----------------------------------------------------------------------------
// spi_front
// Take a segment word, find its segment count by stepping n*spacing squared
// against the squared length.
// ----------------------------------------------------------------------------
module spi_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic [31:0]            i_spacing,
    input  logic signed [31:0]     i_start_x,
    input  logic signed [31:0]     i_end_x,
    input  logic signed [31:0]     i_start_y,
    input  logic signed [31:0]     i_end_y,
    output logic                   o_job_valid,
    output spi_pkg::t_job          o_job,
    input  logic                   i_job_ready
);
    typedef enum logic [2:0] {S_IDLE, S_SQX, S_SQY, S_SQS, S_ADD, S_CMP, S_DONE} t_state;

    t_state             r_state;
    spi_pkg::t_job      r_job;
    logic [31:0]        r_ax, r_ay;
    logic [64:0]        r_sq;
    logic [63:0]        r_s2;
    logic [71:0]        r_step;
    logic [75:0]        r_nsq;
    logic [spi_pkg::CntW-1:0] r_n;

    logic signed [32:0] w_dx, w_dy;
    logic [63:0]        w_s2;
    assign w_dx = 33'(i_end_x) - 33'(i_start_x);
    assign w_dy = 33'(i_end_y) - 33'(i_start_y);
    assign w_s2 = 64'(i_spacing) * 64'(i_spacing);

    assign o_busy      = (r_state != S_IDLE);
    assign o_job_valid = (r_state == S_DONE);
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (i_start) begin
                    r_job.start_x <= i_start_x;
                    r_job.start_y <= i_start_y;
                    r_job.dx      <= w_dx;
                    r_job.dy      <= w_dy;
                    r_ax <= w_dx[32] ? 32'(-w_dx) : w_dx[31:0];
                    r_ay <= w_dy[32] ? 32'(-w_dy) : w_dy[31:0];
                    r_state <= S_SQX;
                end
                S_SQX: begin
                    r_sq    <= 65'(64'(r_ax) * 64'(r_ax));
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_sq    <= r_sq + 65'(64'(r_ay) * 64'(r_ay));
                    r_state <= S_SQS;
                end
                S_SQS: begin
                    r_s2    <= w_s2;
                    r_step  <= 72'(w_s2);
                    r_nsq   <= '0;
                    r_n     <= '0;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_nsq   <= r_nsq + 76'(r_step);
                    r_step  <= r_step + {7'b0, r_s2, 1'b0};
                    r_n     <= r_n + spi_pkg::CntW'(1);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_nsq >= 76'(r_sq)) begin
                        r_job.count   <= r_n;
                        r_job.clipped <= 1'b0;
                        r_state       <= S_DONE;
                    end else if (r_n == spi_pkg::CntW'(spi_pkg::MaxPoints - 1)) begin
                        r_job.count   <= r_n;
                        r_job.clipped <= 1'b1;
                        r_state       <= S_DONE;
                    end else begin
                        r_state <= S_ADD;
                    end
                end
                S_DONE: if (i_job_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/spi_back.sv
// ----------------------------------------------------------------------------
// spi_back
// Divide deltas by the count with a restoring divider, then emit the points.
// ----------------------------------------------------------------------------
module spi_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_job_valid,
    input  spi_pkg::t_job          i_job,
    output logic                   o_job_ready,
    output logic                   o_valid,
    output logic signed [31:0]     o_point_x,
    output logic signed [31:0]     o_point_y,
    output logic [5:0]             o_point_index,
    output logic                   o_count_clipped,
    output logic                   o_last_point
);
    typedef enum logic [1:0] {S_IDLE, S_DIV, S_EMIT} t_state;

    t_state             r_state;
    spi_pkg::t_job      r_job;
    logic [32:0]        r_qx, r_qy;
    logic [spi_pkg::CntW:0] r_rx, r_ry;
    logic [5:0]         r_bit;
    logic signed [31:0] r_px, r_py, r_stx, r_sty;
    logic [spi_pkg::CntW-1:0] r_i;

    logic [spi_pkg::CntW:0] w_tx, w_ty, w_d;
    logic                   w_gx, w_gy;
    assign w_d  = {1'b0, r_job.count};
    assign w_tx = {r_rx[spi_pkg::CntW-1:0], r_qx[32]};
    assign w_ty = {r_ry[spi_pkg::CntW-1:0], r_qy[32]};
    assign w_gx = (w_tx >= w_d);
    assign w_gy = (w_ty >= w_d);

    assign o_job_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_job_valid) begin
                    r_job <= i_job;
                    r_qx  <= i_job.dx[32] ? 33'(-i_job.dx) : 33'(i_job.dx);
                    r_qy  <= i_job.dy[32] ? 33'(-i_job.dy) : 33'(i_job.dy);
                    r_rx  <= '0;
                    r_ry  <= '0;
                    r_bit <= 6'd33;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_bit == 6'd0) begin
                        r_stx <= r_job.dx[32] ? 32'(-r_qx) : r_qx[31:0];
                        r_sty <= r_job.dy[32] ? 32'(-r_qy) : r_qy[31:0];
                        r_px  <= r_job.start_x;
                        r_py  <= r_job.start_y;
                        r_i   <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_rx  <= w_gx ? w_tx - w_d : w_tx;
                        r_ry  <= w_gy ? w_ty - w_d : w_ty;
                        r_qx  <= {r_qx[31:0], w_gx};
                        r_qy  <= {r_qy[31:0], w_gy};
                        r_bit <= r_bit - 6'd1;
                    end
                end
                S_EMIT: begin
                    o_valid         <= 1'b1;
                    o_point_x       <= r_px;
                    o_point_y       <= r_py;
                    o_point_index   <= 6'(r_i);
                    o_count_clipped <= r_job.clipped;
                    o_last_point    <= (r_i == r_job.count);
                    r_px <= r_px + r_stx;
                    r_py <= r_py + r_sty;
                    r_i  <= r_i + spi_pkg::CntW'(1);
                    if (r_i == r_job.count) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/spi_queue.sv
// ----------------------------------------------------------------------------
// spi_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module spi_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  spi_pkg::t_job i_job,
    output logic          o_ready,
    output logic          o_valid,
    output spi_pkg::t_job o_job,
    input  logic          i_ready
);
    spi_pkg::t_job r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

FILE: rtl/segment_point_interpolator_core.sv
// ----------------------------------------------------------------------------
// segment_point_interpolator_core
// Subdivide a segment into evenly spaced Q16.16 points.
//
// channel  | handshake           | word
// segment  | i_start / o_busy    | start_x, end_x, start_y, end_y
// spacing  | i_cfg_valid / ready | spacing
// point    | o_valid             | point_x/y, index, clipped, last
//
// Front: load the segment, square x, add y squared, square the spacing, then
// add and compare per candidate count (up to 63), then hand the job to the queue.
// Back: load, run the restoring divider, then emit count+1 points one per cycle.
// Reset is synchronous; points cannot be stalled.
// ----------------------------------------------------------------------------
module segment_point_interpolator_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_end_y,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic [5:0]         o_point_index,
    output logic               o_count_clipped,
    output logic               o_last_point
);
    logic [31:0]   r_spacing;
    logic          w_fv, w_fr, w_bv, w_br;
    spi_pkg::t_job w_fj, w_bj;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_spacing <= spi_pkg::SpacingRst;
        else if (i_cfg_valid) r_spacing <= i_cfg_data;
    end

    spi_front u_front (
        .i_clk, .i_rst_n, .i_start, .o_busy, .i_spacing(r_spacing),
        .i_start_x, .i_end_x, .i_start_y, .i_end_y,
        .o_job_valid(w_fv), .o_job(w_fj), .i_job_ready(w_fr)
    );
    spi_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(w_fv), .i_job(w_fj), .o_ready(w_fr),
        .o_valid(w_bv), .o_job(w_bj), .i_ready(w_br)
    );
    spi_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(w_bv), .i_job(w_bj), .o_job_ready(w_br),
        .o_valid, .o_point_x, .o_point_y, .o_point_index,
        .o_count_clipped, .o_last_point
    );

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_point |-> o_point_index != 6'd0) else $error("last at index 0");
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !$past(o_valid) |-> o_point_index == 6'd0) else $error("run not at 0");
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(o_valid) && !$past(o_last_point)
        |-> o_point_index == $past(o_point_index) + 6'd1) else $error("index skip");
endmodule
